[rtl/core/tpdc_pkg.sv]
// ----------------------------------------------------------------------------
// tpdc_pkg
// Types and constants shared by the tuner PLL divider calculator.
// ----------------------------------------------------------------------------
package tpdc_pkg;

  localparam int unsigned FREQ_W  = 20;
  localparam int unsigned PLL_W   = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TUNED_W = 18;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_khz;
    logic              force_fine_step;
  } in_t;

  typedef struct packed {
    logic               valid_res;
    logic [PLL_W-1:0]   pll_divider;
    logic [BYTE_W-1:0]  band_byte;
    logic [TUNED_W-1:0] tuned_khz;
  } out_t;

  // Intermediate frequency in kHz
  localparam logic [TUNED_W-1:0] IF_KHZ = 18'd10700;

  // Band limits, inclusive
  localparam logic [FREQ_W-1:0] FM_LO         = 20'd55000;
  localparam logic [FREQ_W-1:0] FM_HI         = 20'd150000;
  localparam logic [FREQ_W-1:0] FM_COARSE_MAX = 20'd108000;
  localparam logic [FREQ_W-1:0] LW_LO         = 20'd100;
  localparam logic [FREQ_W-1:0] LW_HI         = 20'd1900;
  localparam logic [FREQ_W-1:0] SW1_HI        = 20'd5899;
  localparam logic [FREQ_W-1:0] SW2_HI        = 20'd13870;
  localparam logic [FREQ_W-1:0] SW3_HI        = 20'd19020;
  localparam logic [FREQ_W-1:0] SW4_HI        = 20'd30000;

  // Band control bytes
  localparam logic [BYTE_W-1:0] BYTE_FM_COARSE = 8'b0010_0001;
  localparam logic [BYTE_W-1:0] BYTE_FM_FINE   = 8'b0011_0001;
  localparam logic [BYTE_W-1:0] BYTE_LWMW      = 8'b1110_1101;
  localparam logic [BYTE_W-1:0] BYTE_SW1       = 8'b1101_0001;
  localparam logic [BYTE_W-1:0] BYTE_SW2       = 8'b1011_0001;
  localparam logic [BYTE_W-1:0] BYTE_SW3       = 8'b1001_0001;
  localparam logic [BYTE_W-1:0] BYTE_SW4       = 8'b0111_0001;

endpackage

[rtl/core/tpdc_cdiv.sv]
// ----------------------------------------------------------------------------
// tpdc_cdiv
// Truncating division by a constant through a reciprocal multiply.
// Exact as long as X_W bits times the rounding error of the reciprocal
// stay below 2**SHIFT.
// ----------------------------------------------------------------------------
module tpdc_cdiv #(
  parameter int unsigned X_W   = 18,
  parameter int unsigned Q_W   = 16,
  parameter int unsigned DIV   = 5,
  parameter int unsigned SHIFT = 20
) (
  input  logic [X_W-1:0] x,
  output logic [Q_W-1:0] q
);

  localparam int unsigned RECIP = ((1 << SHIFT) + DIV - 1) / DIV;
  localparam int unsigned M_W   = $clog2(RECIP + 1);
  localparam int unsigned P_W   = X_W + M_W;

  localparam logic [M_W-1:0] RECIP_C = M_W'(RECIP);

  logic [P_W-1:0] prod;

  assign prod = P_W'(x) * P_W'(RECIP_C);
  assign q    = prod[SHIFT +: Q_W];

endmodule

[rtl/core/tuner_pll_divider_calc_unit.sv]
// ----------------------------------------------------------------------------
// tuner_pll_divider_calc_unit
// PLL divider, band byte and back-computed tuned frequency from a kHz request.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled and returns
// one result per request. The work runs through five register stages: band
// decode, divide by five, divide by fifty and remainder checks, divider and
// back-multiply, divide by three and IF subtraction into the output register.
// An output stall freezes the whole pipeline; a one-entry skid register at
// the input absorbs the request that arrives in that cycle, so in_stall is a
// register and never follows out_stall combinationally.
module tuner_pll_divider_calc_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tpdc_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tpdc_pkg::out_t out_data
);

  typedef enum logic [2:0] {
    BAND_NONE,
    BAND_FM,
    BAND_LWMW,
    BAND_SW1,
    BAND_SW2,
    BAND_SW3,
    BAND_SW4
  } band_t;

  logic          en;
  logic          skid_full;
  tpdc_pkg::in_t skid;
  tpdc_pkg::in_t src;
  logic          v0;

  // stage 0 decode
  band_t       band0;
  logic [17:0] s0;

  // stage 1
  logic        v1;
  band_t       band1;
  logic [17:0] s1;
  logic        fine1;
  logic        le1;
  logic [17:0] x1;
  logic [15:0] q1_next;

  // stage 2
  logic        v2;
  band_t       band2;
  logic [17:0] s2;
  logic [15:0] q2;
  logic        fine2;
  logic        le2;
  logic [17:0] five_q2;
  logic [12:0] q50_next;

  // stage 3
  logic        v3;
  band_t       band3;
  logic [17:0] s3;
  logic [15:0] q3;
  logic [12:0] q50_3;
  logic        fine3;
  logic        le3;
  logic        r5z3;
  logic [15:0] five_q50;
  logic        coarse;
  logic [15:0] p_next;
  logic [7:0]  byte_next;
  logic [17:0] p18;
  logic [17:0] p5;
  logic [17:0] t_next;
  logic        ok_next;

  // stage 4
  logic        v4;
  logic [15:0] p4;
  logic [7:0]  byte4;
  logic [17:0] t4;
  logic        sw4_4;
  logic        ok4;
  logic [15:0] t_div3;
  logic [17:0] tb;

  assign en       = !(out_valid && out_stall);
  assign in_stall = skid_full;
  assign src      = skid_full ? skid : in_data;
  assign v0       = skid_full || in_valid;

  // Input skid: hold a request that arrives while the pipeline is frozen
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (en) begin
        skid_full <= 1'b0;
      end
    end else if (in_valid && !en) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && in_valid && !en) begin
      skid <= in_data;
    end
  end

  // ---------------------------------------------------------------- stage 0
  always_comb begin
    priority if (src.freq_khz >= tpdc_pkg::FM_LO && src.freq_khz <= tpdc_pkg::FM_HI) begin
      band0 = BAND_FM;
    end else if (src.freq_khz >= tpdc_pkg::LW_LO && src.freq_khz <= tpdc_pkg::LW_HI) begin
      band0 = BAND_LWMW;
    end else if (src.freq_khz > tpdc_pkg::LW_HI && src.freq_khz <= tpdc_pkg::SW1_HI) begin
      band0 = BAND_SW1;
    end else if (src.freq_khz > tpdc_pkg::SW1_HI && src.freq_khz <= tpdc_pkg::SW2_HI) begin
      band0 = BAND_SW2;
    end else if (src.freq_khz > tpdc_pkg::SW2_HI && src.freq_khz <= tpdc_pkg::SW3_HI) begin
      band0 = BAND_SW3;
    end else if (src.freq_khz > tpdc_pkg::SW3_HI && src.freq_khz <= tpdc_pkg::SW4_HI) begin
      band0 = BAND_SW4;
    end else begin
      band0 = BAND_NONE;
    end
  end

  // Only in-band values matter, so the sum fits 18 bits there
  assign s0 = 18'(src.freq_khz[17:0] + tpdc_pkg::IF_KHZ);

  always_ff @(posedge clk) begin
    if (en) begin
      band1 <= band0;
      s1    <= s0;
      fine1 <= src.force_fine_step;
      le1   <= (src.freq_khz <= tpdc_pkg::FM_COARSE_MAX);
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Scale the sum so that a single divide by five serves FM, SW1, SW3 and SW4
  always_comb begin
    unique case (band1)
      BAND_SW1: x1 = {s1[14:0], 3'b000};
      BAND_SW3: x1 = {s1[15:0], 2'b00};
      BAND_SW4: x1 = s1 + {s1[16:0], 1'b0};
      default:  x1 = s1;
    endcase
  end

  tpdc_cdiv #(
    .X_W  (18),
    .Q_W  (16),
    .DIV  (5),
    .SHIFT(20)
  ) u_div5 (
    .x(x1),
    .q(q1_next)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      band2 <= band1;
      s2    <= s1;
      q2    <= q1_next;
      fine2 <= fine1;
      le2   <= le1;
    end
  end

  // ---------------------------------------------------------------- stage 2
  assign five_q2 = {q2, 2'b00} + {2'b00, q2};

  // s / 50 = (s / 5 / 2) / 5
  tpdc_cdiv #(
    .X_W  (15),
    .Q_W  (13),
    .DIV  (5),
    .SHIFT(17)
  ) u_div50 (
    .x(q2[15:1]),
    .q(q50_next)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      band3 <= band2;
      s3    <= s2;
      q3    <= q2;
      q50_3 <= q50_next;
      fine3 <= fine2;
      le3   <= le2;
      r5z3  <= (five_q2 == s2);
    end
  end

  // ---------------------------------------------------------------- stage 3
  assign five_q50 = {1'b0, q50_3, 2'b00} + {3'b000, q50_3};

  // IF is a multiple of 50, so the sum is too exactly when the request is
  assign coarse = (band3 == BAND_FM) && r5z3 && !q3[0] &&
                  (five_q50 == {1'b0, q3[15:1]}) && le3 && !fine3;

  always_comb begin
    unique case (band3)
      BAND_FM: begin
        p_next    = coarse ? {3'b000, q50_3} : q3;
        byte_next = coarse ? tpdc_pkg::BYTE_FM_COARSE : tpdc_pkg::BYTE_FM_FINE;
      end
      BAND_LWMW: begin
        p_next    = s3[15:0];
        byte_next = tpdc_pkg::BYTE_LWMW;
      end
      BAND_SW1: begin
        p_next    = q3;
        byte_next = tpdc_pkg::BYTE_SW1;
      end
      BAND_SW2: begin
        p_next    = s3[15:0];
        byte_next = tpdc_pkg::BYTE_SW2;
      end
      BAND_SW3: begin
        p_next    = q3;
        byte_next = tpdc_pkg::BYTE_SW3;
      end
      BAND_SW4: begin
        p_next    = q3;
        byte_next = tpdc_pkg::BYTE_SW4;
      end
      default: begin
        p_next    = '0;
        byte_next = '0;
      end
    endcase
  end

  assign p18     = {2'b00, p_next};
  assign p5      = {p18[15:0], 2'b00} + p18;
  assign ok_next = (band3 != BAND_NONE);

  // Back-multiply: frequency before the IF is removed
  always_comb begin
    unique case (band3)
      BAND_FM:  t_next = coarse ? ({p18[12:0], 5'b00000} + {p18[13:0], 4'b0000} +
                                   {p18[16:0], 1'b0}) : p5;
      BAND_SW1: t_next = {3'b000, p5[17:3]};
      BAND_SW3: t_next = {2'b00, p5[17:2]};
      BAND_SW4: t_next = p5;
      default:  t_next = p18;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4    <= p_next;
      byte4 <= byte_next;
      t4    <= t_next;
      sw4_4 <= (band3 == BAND_SW4);
      ok4   <= ok_next;
    end
  end

  // ---------------------------------------------------------------- stage 4
  tpdc_cdiv #(
    .X_W  (17),
    .Q_W  (16),
    .DIV  (3),
    .SHIFT(18)
  ) u_div3 (
    .x(t4[16:0]),
    .q(t_div3)
  );

  assign tb = sw4_4 ? {2'b00, t_div3} : t4;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.valid_res   <= ok4;
      out_data.pll_divider <= p4;
      out_data.band_byte   <= byte4;
      out_data.tuned_khz   <= (tb < tpdc_pkg::IF_KHZ) ? '0 : tb - tpdc_pkg::IF_KHZ;
    end
  end

  // Valid bits travel with the data and freeze on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= v0;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the tuner PLL divider calculator.
// ----------------------------------------------------------------------------
// Drives kHz tuning requests through the valid/stall channel and predicts
// the band byte, the PLL divider and the back-computed tuned frequency of
// every accepted request. Each result is checked field by field against the
// oldest prediction. Runs directed band edges first, then random requests
// under several idle and stall mixes, a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES  = 150;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  tpdc_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  tpdc_pkg::out_t out_data;

  tpdc_pkg::out_t pending_tunes[$];
  int unsigned    mismatch_count = 0;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    hold_left      = 0;
  int unsigned    quiet_cycles   = 0;

  int unsigned band_edges[18] = '{99, 100, 1900, 1901, 5899, 5900, 13870, 13871,
                                  19020, 19021, 30000, 30001, 54999, 55000,
                                  108000, 108050, 150000, 150001};
  int unsigned directed_freqs[21] = '{0, 99, 100, 1900, 1901, 5899, 5900, 13870,
                                      13871, 19020, 19021, 30000, 30001, 54999,
                                      55000, 107999, 108000, 108050, 150000,
                                      150001, 1048575};
  int unsigned fine_freqs[3] = '{55000, 108000, 150000};

  tuner_pll_divider_calc_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Band decode, divider and tuned frequency for one request
  function automatic tpdc_pkg::out_t compute_tuning(tpdc_pkg::in_t req);
    tpdc_pkg::out_t res;
    int unsigned    f;
    int unsigned    if_khz;
    int unsigned    sum;
    int unsigned    pll;
    int unsigned    back_mul;
    int unsigned    back_div;
    int unsigned    back;
    logic [tpdc_pkg::BYTE_W-1:0] band;
    res    = '0;
    f      = 32'(req.freq_khz);
    if_khz = 32'(tpdc_pkg::IF_KHZ);
    sum    = f + if_khz;
    if (req.freq_khz >= tpdc_pkg::FM_LO && req.freq_khz <= tpdc_pkg::FM_HI) begin
      if ((f % 50) != 0 || req.freq_khz > tpdc_pkg::FM_COARSE_MAX ||
          req.force_fine_step) begin
        pll = sum * 2 / 10;
        band = tpdc_pkg::BYTE_FM_FINE;
        back_mul = 10;
        back_div = 2;
      end else begin
        pll = sum * 2 / 100;
        band = tpdc_pkg::BYTE_FM_COARSE;
        back_mul = 100;
        back_div = 2;
      end
    end else if (req.freq_khz >= tpdc_pkg::LW_LO && req.freq_khz <= tpdc_pkg::LW_HI) begin
      pll = sum;
      band = tpdc_pkg::BYTE_LWMW;
      back_mul = 20;
      back_div = 20;
    end else if (req.freq_khz > tpdc_pkg::LW_HI && req.freq_khz <= tpdc_pkg::SW1_HI) begin
      pll = sum * 16 / 10;
      band = tpdc_pkg::BYTE_SW1;
      back_mul = 10;
      back_div = 16;
    end else if (req.freq_khz > tpdc_pkg::SW1_HI && req.freq_khz <= tpdc_pkg::SW2_HI) begin
      pll = sum;
      band = tpdc_pkg::BYTE_SW2;
      back_mul = 10;
      back_div = 10;
    end else if (req.freq_khz > tpdc_pkg::SW2_HI && req.freq_khz <= tpdc_pkg::SW3_HI) begin
      pll = sum * 8 / 10;
      band = tpdc_pkg::BYTE_SW3;
      back_mul = 10;
      back_div = 8;
    end else if (req.freq_khz > tpdc_pkg::SW3_HI && req.freq_khz <= tpdc_pkg::SW4_HI) begin
      pll = sum * 6 / 10;
      band = tpdc_pkg::BYTE_SW4;
      back_mul = 10;
      back_div = 6;
    end else begin
      return res;
    end
    pll  = pll & 32'hFFFF;
    back = back_mul * pll / back_div;
    back = (back < if_khz) ? 0 : back - if_khz;
    res.valid_res   = 1'b1;
    res.pll_divider = pll[tpdc_pkg::PLL_W-1:0];
    res.band_byte   = band;
    res.tuned_khz   = back[tpdc_pkg::TUNED_W-1:0];
    return res;
  endfunction

  function automatic tpdc_pkg::in_t random_request();
    tpdc_pkg::in_t req;
    int unsigned   f;
    case ($urandom_range(9))
      0: f = 32'(tpdc_pkg::FM_LO) + 50 * $urandom_range(1060);
      1: f = $urandom_range(150000, 55000);
      2: f = $urandom_range(1900, 100);
      3: f = $urandom_range(5899, 1901);
      4: f = $urandom_range(13870, 5900);
      5: f = $urandom_range(19020, 13871);
      6: f = $urandom_range(30000, 19021);
      7: f = band_edges[$urandom_range(17)] + $urandom_range(2) - 1;
      8: begin
        case ($urandom_range(2))
          0: f = $urandom_range(99);
          1: f = $urandom_range(54999, 30001);
          default: f = $urandom_range(1048575, 150001);
        endcase
      end
      default: f = $urandom;
    endcase
    req.freq_khz        = f[tpdc_pkg::FREQ_W-1:0];
    req.force_fine_step = 1'($urandom_range(1));
    return req;
  endfunction

  // Record a prediction for every accepted request
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      pending_tunes.push_back(compute_tuning(in_data));
  end

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    tpdc_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tunes.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
        mismatch_count++;
      end else begin
        want = pending_tunes.pop_front();
        check_field("valid_res", 32'(want.valid_res), 32'(out_data.valid_res));
        check_field("pll_divider", 32'(want.pll_divider), 32'(out_data.pll_divider));
        check_field("band_byte", 32'(want.band_byte), 32'(out_data.band_byte));
        check_field("tuned_khz", 32'(want.tuned_khz), 32'(out_data.tuned_khz));
      end
    end
  end

  // Output side: hold off for a counted stretch when asked, else stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input tpdc_pkg::in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tunes.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  task automatic test_directed();
    tpdc_pkg::in_t req;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (directed_freqs[i]) begin
      req.freq_khz        = directed_freqs[i][tpdc_pkg::FREQ_W-1:0];
      req.force_fine_step = 1'b0;
      send_request(req);
    end
    // FM requests with the force flag; the first two would take the coarse step without it
    foreach (fine_freqs[i]) begin
      req.freq_khz        = fine_freqs[i][tpdc_pkg::FREQ_W-1:0];
      req.force_fine_step = 1'b1;
      send_request(req);
    end
    wait_drained();
  endtask

  task automatic test_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(100);
    wait_drained();
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 55;
    recv_stall_pct = 0;
    run_random(100);
    wait_drained();
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 55;
    run_random(100);
    wait_drained();
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    run_random(100);
    wait_drained();
  endtask

  // Keep offering requests while the output is held so the pipe fills and stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    run_random(40);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    repeat (4) begin
      run_random(10);
      wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    test_drain_pause();
    recv_stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_tunes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tpdc_pkg.sv
rtl/core/tpdc_cdiv.sv
rtl/core/tuner_pll_divider_calc_unit.sv
dv/tb.sv
